@@ design/slfs_pkg.sv @@
// Shared types and constants for the sync/length frame splitter.
// Used by the parser, the top level and the port checker.
package slfs_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int FLEN_W  = 17;
    localparam int POS_W   = 2;
    localparam int DATA_W  = BYTE_W + LEN_W + FLEN_W;   // 41 bits of fields
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;    // padded to 48
    localparam int TUSER_W = 3;                          // first flag, status

    // Three header bytes: sync byte and two length bytes.
    localparam logic [FLEN_W-1:0] HEADER_BYTES = 17'd3;

    localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'hFF;
    localparam logic [LEN_W-1:0]  MIN_LEN_RESET = 16'd3;

    // Configuration register indexes.
    localparam logic CFG_SYNC_VALUE = 1'b0;
    localparam logic CFG_MIN_BODY   = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SYNC_ERR = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    // Body positions that the message number is gathered from.
    localparam logic [POS_W-1:0] POS_NUM_LO = 2'd0;
    localparam logic [POS_W-1:0] POS_NUM_HI = 2'd1;
    localparam logic [POS_W-1:0] POS_DONE   = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_LEN_LO = 4'b0010,
        PH_LEN_HI = 4'b0100,
        PH_BODY   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [FLEN_W-1:0] frame_length;
        logic [LEN_W-1:0]  message_number;
        logic [BYTE_W-1:0] frame_byte;
        logic [1:0]        status;
        logic              first_of_frame;
        logic              last_of_frame;
    } result_t;

endpackage

@@ design/slfs_parser.sv @@
// Frame parser: configuration registers, parse state and the result for
// the byte on its input. Depends on slfs_pkg.
module slfs_parser
    import slfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    output result_t           result
);

    logic [BYTE_W-1:0] sync_value_reg;
    logic [LEN_W-1:0]  min_body_reg;

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  body_length_reg, body_length_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [LEN_W-1:0]  number_reg, number_next;

    logic [LEN_W-1:0]  length_full;
    logic [LEN_W-1:0]  remaining_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg <= SYNC_RESET;
            min_body_reg   <= MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_VALUE: sync_value_reg <= cfg_data[BYTE_W-1:0];
                CFG_MIN_BODY:   min_body_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign length_full   = {data_byte, body_length_reg[BYTE_W-1:0]};
    assign remaining_dec = remaining_reg - LEN_W'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        body_length_next = body_length_reg;
        remaining_next   = remaining_reg;
        position_next    = position_reg;
        number_next      = number_reg;

        result                = '0;
        result.frame_byte     = data_byte;
        result.status         = ST_OK;

        case (phase_reg)
            PH_LEN_LO:
            begin
                body_length_next = {{(LEN_W-BYTE_W){1'b0}}, data_byte};
                phase_next       = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                body_length_next = length_full;
                number_next      = '0;
                position_next    = POS_NUM_LO;
                if (length_full < min_body_reg)
                begin
                    phase_next    = PH_HUNT;
                    result.status = ST_SHORT;
                end
                else if (length_full == '0)
                begin
                    // Empty body: the frame ends on the length high byte.
                    phase_next          = PH_HUNT;
                    remaining_next      = '0;
                    result.last_of_frame = 1'b1;
                    result.frame_length = HEADER_BYTES;
                end
                else
                begin
                    remaining_next = length_full;
                    phase_next     = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (position_reg == POS_NUM_LO)
                begin
                    number_next   = {{(LEN_W-BYTE_W){1'b0}}, data_byte};
                    position_next = POS_NUM_HI;
                end
                else if (position_reg == POS_NUM_HI)
                begin
                    number_next   = {data_byte, number_reg[BYTE_W-1:0]};
                    position_next = POS_DONE;
                end
                remaining_next = remaining_dec;
                if (remaining_dec == '0)
                begin
                    phase_next            = PH_HUNT;
                    result.last_of_frame  = 1'b1;
                    result.message_number = number_next;
                    result.frame_length   = {1'b0, body_length_reg} + HEADER_BYTES;
                end
            end
            default:
            begin
                if (data_byte == sync_value_reg)
                begin
                    phase_next            = PH_LEN_LO;
                    body_length_next      = '0;
                    remaining_next        = '0;
                    position_next         = POS_NUM_LO;
                    number_next           = '0;
                    result.first_of_frame = 1'b1;
                end
                else
                begin
                    phase_next        = PH_HUNT;
                    result.frame_byte = '0;
                    result.status     = ST_SYNC_ERR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            body_length_reg <= '0;
            remaining_reg   <= '0;
            position_reg    <= POS_NUM_LO;
            number_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            body_length_reg <= body_length_next;
            remaining_reg   <= remaining_next;
            position_reg    <= position_next;
            number_reg      <= number_next;
        end
    end

endmodule

@@ design/sync_length_frame_splitter.sv @@
// The result for an accepted byte is registered in the output register, or in the
// skid register while the output register is stalled. Throughput: one byte per cycle while m_tready stays high.
// The output register is backed by a one-entry skid register, so s_tready
// only falls after a stall has left both of them full.
// Reset (rst_n, asynchronous, active low) returns the parser to hunting,
// empties both output registers and restores the configuration registers.
module sync_length_frame_splitter
    import slfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [LEN_W-1:0]   cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,     // [7:0] data_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,     // [7:0] frame_byte, [23:8] message_number,
                                            // [40:24] frame_length, [47:41] zero
    output logic               m_tlast,
    output logic [TUSER_W-1:0] m_tuser      // [0] first_of_frame, [2:1] status
);

    result_t result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;
    logic    pop;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    slfs_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (s_tdata),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-DATA_W){1'b0}}, out_reg.frame_length,
                       out_reg.message_number, out_reg.frame_byte};
    assign m_tlast  = out_reg.last_of_frame;
    assign m_tuser  = {out_reg.status, out_reg.first_of_frame};

endmodule

@@ design/slfs_checker.sv @@
// Port-level checker for the frame splitter, bound to the top level.
// Depends on slfs_pkg.
module slfs_checker
    import slfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               m_tlast,
    input  logic [TUSER_W-1:0] m_tuser
);

    // A stalled transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("master payload changed while stalled");

    // A frame ends only on a byte with OK status, never on the byte that opens it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[2:1] == ST_OK && !m_tuser[0])
        else $error("last byte with bad status or first mark");

    // Number and length are shown only with the last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[TDATA_W-1:BYTE_W] == '0)
        else $error("number or length outside the last byte");

    // A dropped byte is shown as zero and never marks a frame edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:1] == ST_SYNC_ERR |->
            m_tdata[BYTE_W-1:0] == '0 && !m_tuser[0] && !m_tlast)
        else $error("sync error transfer carries data or marks");

    // Status code three is never produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[2:1] != 2'd3)
        else $error("undefined status code");

endmodule

bind sync_length_frame_splitter slfs_checker u_slfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
